FILE: rtl/blc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Black level correction package
// Shared widths, register and channel codes, CFA channel tables and the
// channel lookup used by the black level correction pipeline.
// ----------------------------------------------------------------------------
package blc_pkg;

    // Pixel precision kept inside the pipeline.
    localparam int unsigned PIXEL_BITS = 14;
    localparam int unsigned RAW_W      = 16;
    localparam int unsigned PSHIFT     = RAW_W - PIXEL_BITS;
    localparam int unsigned PMAX_INT   = (1 << PIXEL_BITS) - 1;
    localparam logic [PIXEL_BITS-1:0] PMAX = PIXEL_BITS'(PMAX_INT);

    // Register field widths.
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFA_W      = 4;
    localparam int unsigned OFS_W      = 15;
    localparam int unsigned WL_W       = 14;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned NUM_CH     = 5;

    // Normalization ratio: (PMAX * 1024) / white level, kept to 24 bits.
    localparam int unsigned RATIO_W    = 24;
    localparam int unsigned FRAC_BITS  = 10;
    localparam int unsigned RATIO_ONE  = 1 << FRAC_BITS;
    localparam int unsigned ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int unsigned DIV_NUM    = PMAX_INT * RATIO_ONE;
    localparam int unsigned DIV_NUM_W  = PIXEL_BITS + FRAC_BITS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int unsigned WL_RST     = 16383;
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(DIV_NUM / WL_RST);

    // Datapath widths.
    localparam int unsigned DIFF_W = ((PIXEL_BITS > OFS_W) ? PIXEL_BITS : OFS_W) + 2;
    localparam int unsigned PROD_W = PIXEL_BITS + RATIO_W;

    // Mode codes; bit one set means normalize.
    localparam logic [MODE_W-1:0] MODE_BYPASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NORMALIZE = 2'd2;
    localparam int unsigned       MODE_NORM_BIT  = 1;

    // CFA pattern code boundaries.
    localparam logic [CFA_W-1:0] CFA_RGGB        = 4'd0;
    localparam logic [CFA_W-1:0] CFA_LAST_BAYER  = 4'd3;
    localparam logic [CFA_W-1:0] CFA_FIRST_RGBIR = 4'd4;
    localparam logic [CFA_W-1:0] CFA_LAST_RGBIR  = 4'd11;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE              = 3'd0,
        REG_CFA_PATTERN       = 3'd1,
        REG_OFFSET_RED        = 3'd2,
        REG_OFFSET_GREEN_RED  = 3'd3,
        REG_OFFSET_GREEN_BLUE = 3'd4,
        REG_OFFSET_BLUE       = 3'd5,
        REG_OFFSET_INFRARED   = 3'd6,
        REG_WHITE_LEVEL       = 3'd7
    } t_cfg_idx;

    // Color channels.
    typedef enum logic [2:0] {
        CH_R  = 3'd0,
        CH_GR = 3'd1,
        CH_GB = 3'd2,
        CH_B  = 3'd3,
        CH_IR = 3'd4
    } t_chan;

    // Bayer 2x2 layouts, indexed by {row[0], col[0]}.
    localparam t_chan BAYER_TAB [4][4] = '{
        '{CH_R,  CH_GR, CH_GB, CH_B },
        '{CH_GR, CH_R,  CH_B,  CH_GB},
        '{CH_GB, CH_B,  CH_R,  CH_GR},
        '{CH_B,  CH_GB, CH_GR, CH_R }
    };

    // RGB-IR 4x4 layouts, indexed by {row, col}.
    localparam t_chan RGBIR_TAB [8][16] = '{
        '{CH_R,  CH_GR, CH_B,  CH_GB, CH_GB, CH_IR, CH_GR, CH_IR,
          CH_B,  CH_GB, CH_R,  CH_GR, CH_GR, CH_IR, CH_GB, CH_IR},
        '{CH_B,  CH_GB, CH_R,  CH_GR, CH_GR, CH_IR, CH_GB, CH_IR,
          CH_R,  CH_GR, CH_B,  CH_GB, CH_GB, CH_IR, CH_GR, CH_IR},
        '{CH_GR, CH_R,  CH_GB, CH_B,  CH_IR, CH_GB, CH_IR, CH_GR,
          CH_GB, CH_B,  CH_GR, CH_R,  CH_IR, CH_GR, CH_IR, CH_GB},
        '{CH_GB, CH_B,  CH_GR, CH_R,  CH_IR, CH_GR, CH_IR, CH_GB,
          CH_GR, CH_R,  CH_GB, CH_B,  CH_IR, CH_GB, CH_IR, CH_GR},
        '{CH_IR, CH_GB, CH_IR, CH_GR, CH_GR, CH_R,  CH_GB, CH_B,
          CH_IR, CH_GR, CH_IR, CH_GB, CH_GB, CH_B,  CH_GR, CH_R },
        '{CH_GR, CH_IR, CH_GB, CH_IR, CH_B,  CH_GB, CH_R,  CH_GR,
          CH_GB, CH_IR, CH_GR, CH_IR, CH_R,  CH_GR, CH_B,  CH_GB},
        '{CH_IR, CH_GR, CH_IR, CH_GB, CH_GB, CH_B,  CH_GR, CH_R,
          CH_IR, CH_GB, CH_IR, CH_GR, CH_GR, CH_R,  CH_GB, CH_B },
        '{CH_GB, CH_IR, CH_GR, CH_IR, CH_R,  CH_GR, CH_B,  CH_GB,
          CH_GR, CH_IR, CH_GB, CH_IR, CH_B,  CH_GB, CH_R,  CH_GR}
    };

    // Channel of a pixel from the CFA pattern and its row and column phase.
    // Unknown pattern codes fall back to RGGB.
    function automatic t_chan cfa_channel(input logic [CFA_W-1:0] pattern,
                                          input logic [1:0] row,
                                          input logic [1:0] col);
        logic [2:0] ir_sel;
        logic [1:0] bay_sel;
        ir_sel  = 3'(pattern - CFA_FIRST_RGBIR);
        bay_sel = (pattern <= CFA_LAST_BAYER) ? pattern[1:0] : CFA_RGGB[1:0];
        if (pattern >= CFA_FIRST_RGBIR && pattern <= CFA_LAST_RGBIR) begin
            return RGBIR_TAB[ir_sel][{row, col}];
        end
        return BAYER_TAB[bay_sel][{row[0], col[0]}];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/blc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Black level correction channel interfaces
// Valid/ready channels for input pixels, corrected pixels and register writes.
// ----------------------------------------------------------------------------

// Raw pixel item with its row and column phase.
interface blc_pix_in_if;
    logic                           valid;
    logic                           ready;
    logic [blc_pkg::RAW_W-1:0]      pixel_in;
    logic [1:0]                     row_phase;
    logic [1:0]                     col_phase;

    modport source (output valid, output pixel_in, output row_phase,
                    output col_phase, input ready);
    modport sink   (input valid, input pixel_in, input row_phase,
                    input col_phase, output ready);
endinterface

// Corrected pixel item.
interface blc_pix_out_if;
    logic                           valid;
    logic                           ready;
    logic [blc_pkg::RAW_W-1:0]      pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

// Register write channel.
interface blc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [blc_pkg::CFG_IDX_W-1:0]      index;
    logic [blc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/blc_ratio_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Normalization ratio divider
// Restoring divider that computes (PMAX * 1024) / white level one quotient
// bit per cycle and holds the resulting ratio until the next division ends.
// ----------------------------------------------------------------------------
module blc_ratio_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [blc_pkg::WL_W-1:0]         i_full_level,
    output logic                                  o_busy,
    output logic [blc_pkg::RATIO_W-1:0]           o_ratio
);

    logic [blc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [blc_pkg::DIV_NUM_W-1:0]  r_quo;
    logic [blc_pkg::WL_W-1:0]       r_rem;
    logic [blc_pkg::WL_W-1:0]       r_div;
    logic [blc_pkg::RATIO_W-1:0]    r_ratio;

    logic [blc_pkg::WL_W:0]         w_shift;
    logic [blc_pkg::WL_W:0]         w_diff;
    logic                           w_ge;
    logic [blc_pkg::WL_W-1:0]       n_rem;
    logic [blc_pkg::DIV_NUM_W-1:0]  n_quo;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        w_shift = {r_rem, r_quo[blc_pkg::DIV_NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_ge    = (w_shift >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[blc_pkg::WL_W-1:0] : w_shift[blc_pkg::WL_W-1:0];
        n_quo   = {r_quo[blc_pkg::DIV_NUM_W-2:0], w_ge};
    end

    // Step counter and ratio register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ratio <= blc_pkg::RATIO_RST;
        end else if (i_start) begin
            r_cnt <= blc_pkg::DIV_CNT_W'(blc_pkg::DIV_NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == blc_pkg::DIV_CNT_W'(1)) begin
                r_ratio <= n_quo[blc_pkg::RATIO_W-1:0];
            end
        end
    end

    // Dividend, partial remainder and divisor; a zero white level counts as one.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= blc_pkg::DIV_NUM_W'(blc_pkg::DIV_NUM);
            r_rem <= '0;
            r_div <= (i_full_level == '0) ? blc_pkg::WL_W'(1) : i_full_level;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy  = (r_cnt != '0);
    assign o_ratio = r_ratio;

endmodule
`default_nettype wire

FILE: rtl/black_level_correction.sv
`default_nettype none
// Accepted items pass through pipeline stages 1 to 4; stage 4 drives the
// output. Throughput: one item per cycle through the four-stage pipeline
// while the output is ready and no ratio division runs. A white level write
// starts a division; further register writes and input items wait until done.
// Reset (synchronous, active low) empties the pipeline and restores register
// defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
// Black level correction
// Bayer / RGB-IR per-channel offset subtraction with clamp and optional
// normalization to a programmable white level.
// ----------------------------------------------------------------------------
module black_level_correction (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    blc_pix_in_if.sink     i_pix_in,
    blc_pix_out_if.source  o_pix_out,
    blc_cfg_if.sink        i_cfg
);

    localparam int unsigned PW = blc_pkg::PIXEL_BITS;

    // Configuration registers.
    logic [blc_pkg::MODE_W-1:0]       r_mode;
    logic [blc_pkg::CFA_W-1:0]        r_cfa;
    logic signed [blc_pkg::OFS_W-1:0] r_ofs [blc_pkg::NUM_CH];

    logic                             w_cfg_fire;
    blc_pkg::t_cfg_idx                w_cfg_idx;
    logic                             w_div_start;
    logic                             w_div_busy;
    logic [blc_pkg::RATIO_W-1:0]      w_ratio;

    // Pipeline registers.
    logic                             r_v1, r_v2, r_v3, r_v4;
    logic [PW-1:0]                    r_pix1, r_pix2, r_sel3;
    blc_pkg::t_chan                   r_ch1;
    logic [PW-1:0]                    r_clamp2;
    logic [blc_pkg::PROD_W-1:0]       r_prod3;
    logic [blc_pkg::RAW_W-1:0]        r_out4;

    logic                             w_en1, w_en2, w_en3, w_en4;
    logic                             w_in_fire;
    logic signed [blc_pkg::OFS_W-1:0] w_ofs;
    logic signed [blc_pkg::DIFF_W-1:0] w_diff;
    logic [PW-1:0]                    n_clamp;
    logic [blc_pkg::PROD_W:0]         w_round;
    logic [blc_pkg::PROD_W-blc_pkg::FRAC_BITS:0] w_scaled;
    logic [PW-1:0]                    w_norm;
    logic [PW-1:0]                    n_out;

    // Register writes; the ratio divider owns the port while it runs.
    assign i_cfg.ready = !w_div_busy;
    assign w_cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign w_cfg_idx   = blc_pkg::t_cfg_idx'(i_cfg.index);
    assign w_div_start = w_cfg_fire && (w_cfg_idx == blc_pkg::REG_WHITE_LEVEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= blc_pkg::MODE_BYPASS;
            r_cfa  <= blc_pkg::CFA_RGGB;
            for (int i = 0; i < blc_pkg::NUM_CH; i++) begin
                r_ofs[i] <= '0;
            end
        end else if (w_cfg_fire) begin
            unique case (w_cfg_idx)
                blc_pkg::REG_MODE:
                    r_mode <= i_cfg.data[blc_pkg::MODE_W-1:0];
                blc_pkg::REG_CFA_PATTERN:
                    r_cfa <= i_cfg.data[blc_pkg::CFA_W-1:0];
                blc_pkg::REG_OFFSET_RED:
                    r_ofs[blc_pkg::CH_R] <= i_cfg.data[blc_pkg::OFS_W-1:0];
                blc_pkg::REG_OFFSET_GREEN_RED:
                    r_ofs[blc_pkg::CH_GR] <= i_cfg.data[blc_pkg::OFS_W-1:0];
                blc_pkg::REG_OFFSET_GREEN_BLUE:
                    r_ofs[blc_pkg::CH_GB] <= i_cfg.data[blc_pkg::OFS_W-1:0];
                blc_pkg::REG_OFFSET_BLUE:
                    r_ofs[blc_pkg::CH_B] <= i_cfg.data[blc_pkg::OFS_W-1:0];
                blc_pkg::REG_OFFSET_INFRARED:
                    r_ofs[blc_pkg::CH_IR] <= i_cfg.data[blc_pkg::OFS_W-1:0];
                blc_pkg::REG_WHITE_LEVEL: begin
                    // The divider latches the white level itself.
                end
                default: begin
                end
            endcase
        end
    end

    // Ratio divider, restarted on every white level write.
    blc_ratio_div u_ratio_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_div_start),
        .i_full_level  (i_cfg.data[blc_pkg::WL_W-1:0]),
        .o_busy        (w_div_busy),
        .o_ratio       (w_ratio)
    );

    // A stage loads when it is empty or its content moves on.
    assign w_en4 = !r_v4 || o_pix_out.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_pix_in.ready = w_en1 && !w_div_busy;
    assign w_in_fire      = i_pix_in.valid && i_pix_in.ready;

    // Stage 1: truncate the raw pixel and look up its channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= w_in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_pix1 <= i_pix_in.pixel_in[blc_pkg::RAW_W-1 -: PW];
            r_ch1  <= blc_pkg::cfa_channel(r_cfa, i_pix_in.row_phase, i_pix_in.col_phase);
        end
    end

    // Stage 2: subtract the channel offset and clamp to the pixel range.
    always_comb begin
        unique case (r_ch1)
            blc_pkg::CH_R:  w_ofs = r_ofs[blc_pkg::CH_R];
            blc_pkg::CH_GR: w_ofs = r_ofs[blc_pkg::CH_GR];
            blc_pkg::CH_GB: w_ofs = r_ofs[blc_pkg::CH_GB];
            blc_pkg::CH_B:  w_ofs = r_ofs[blc_pkg::CH_B];
            blc_pkg::CH_IR: w_ofs = r_ofs[blc_pkg::CH_IR];
            default:        w_ofs = r_ofs[blc_pkg::CH_R];
        endcase
        w_diff = signed'(blc_pkg::DIFF_W'(r_pix1)) - blc_pkg::DIFF_W'(w_ofs);
        if (w_diff < 0) begin
            n_clamp = '0;
        end else if (w_diff > signed'(blc_pkg::DIFF_W'(blc_pkg::PMAX))) begin
            n_clamp = blc_pkg::PMAX;
        end else begin
            n_clamp = w_diff[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_pix2   <= r_pix1;
            r_clamp2 <= n_clamp;
        end
    end

    // Stage 3: pick bypass or corrected value and scale by the ratio.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_sel3  <= (r_mode == blc_pkg::MODE_BYPASS) ? r_pix2 : r_clamp2;
            r_prod3 <= blc_pkg::PROD_W'(r_clamp2) * blc_pkg::PROD_W'(w_ratio);
        end
    end

    // Stage 4: round, drop the fraction, saturate and realign to 16 bits.
    always_comb begin
        w_round  = (blc_pkg::PROD_W+1)'(r_prod3)
                 + (blc_pkg::PROD_W+1)'(blc_pkg::ROUND_HALF);
        w_scaled = w_round[blc_pkg::PROD_W:blc_pkg::FRAC_BITS];
        if (w_scaled > (blc_pkg::PROD_W-blc_pkg::FRAC_BITS+1)'(blc_pkg::PMAX)) begin
            w_norm = blc_pkg::PMAX;
        end else begin
            w_norm = w_scaled[PW-1:0];
        end
        n_out = r_mode[blc_pkg::MODE_NORM_BIT] ? w_norm : r_sel3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out4 <= blc_pkg::RAW_W'(n_out) << blc_pkg::PSHIFT;
        end
    end

    assign o_pix_out.valid     = r_v4;
    assign o_pix_out.pixel_out = r_out4;

`ifndef NO_ASSERTIONS
    // A white level write must close the input until the new ratio is ready.
    a_ratio_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (w_div_busy && !i_pix_in.ready))
        else $error("item input open while ratio divider runs");

    // A stalled multiply stage keeps its item and its product.
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_en4) |=> (r_v3 && $stable(r_prod3) && $stable(r_sel3)))
        else $error("stalled item lost or changed in multiply stage");

    // Every accepted item enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_v1)
        else $error("accepted item did not enter the pipeline");

    // A full output register under backpressure holds its result.
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !o_pix_out.ready) |=> (r_v4 && $stable(r_out4)))
        else $error("stalled result lost or changed");
`endif

endmodule
`default_nettype wire
